FILE: rtl/ptmb_pkg.sv
package ptmb_pkg;

  localparam int POOL_PAGES = 64;
  localparam int PAGE_W     = $clog2(POOL_PAGES);
  localparam int SLOT_W     = 9;
  localparam int SLOTS      = 1 << SLOT_W;
  localparam int ADDR_W     = PAGE_W + SLOT_W;
  localparam int DEPTH      = POOL_PAGES * SLOTS;
  localparam int PAGE_SHIFT = 12;
  localparam int PPN_W      = 40;
  localparam int ENTRY_W    = 64;
  localparam int VA_W       = 48;
  localparam int PA_W       = 52;
  localparam int IDX_W      = VA_W - PAGE_SHIFT;
  localparam int CNT_W      = 7;
  localparam int LVL_W      = 2;
  localparam int NEED_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 40;

  localparam logic [LVL_W-1:0] LAST_TABLE_LVL = 2'd2;
  localparam logic [LVL_W-1:0] LEAF_LVL       = 2'd3;
  localparam logic [NEED_W-1:0] TABLE_LEVELS  = 2'd3;

  localparam logic KIND_MAP  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic STATUS_DONE      = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT = 1'b1;

  localparam logic [CNT_W-1:0] POOL_LIMIT = CNT_W'((POOL_PAGES > 64) ? 64 : POOL_PAGES);
  localparam logic [CNT_W-1:0] REM_RESET  = POOL_LIMIT - CNT_W'(1);
  localparam logic [CNT_W-1:0] NFI_RESET  = CNT_W'(1);

  localparam logic [PAGE_SHIFT-1:0] FLAGS_PW = 12'h003;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ENTRY_W-1:0] wr_data;
  } ram_req_t;

endpackage

FILE: rtl/ptmb_if.sv
interface ptmb_in_if;
  import ptmb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [VA_W-1:0]      virt_addr;
  logic [PA_W-1:0]      frame_addr;
  logic [PAGE_W-1:0]    read_page;
  logic [SLOT_W-1:0]    read_slot;

  modport source (output valid, kind, virt_addr, frame_addr, read_page, read_slot,
                  input ready);
  modport sink (input valid, kind, virt_addr, frame_addr, read_page, read_slot,
                output ready);
endinterface

interface ptmb_out_if;
  import ptmb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 status;
  logic [ENTRY_W-1:0]   entry_value;
  logic [CNT_W-1:0]     free_pages;

  modport source (output valid, status, entry_value, free_pages, input ready);
  modport sink (input valid, status, entry_value, free_pages, output ready);
endinterface

FILE: rtl/ptmb_table_ram.sv
module ptmb_table_ram (
  input  logic                      clk,
  input  ptmb_pkg::ram_req_t        req,
  output logic [ptmb_pkg::ENTRY_W-1:0] rd_data_r
);
  import ptmb_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

endmodule

FILE: rtl/page_table_mapping_builder_unit.sv
// Builds four-level page tables in a pool of 64 table pages held in one entry memory with
// one read and one write port (read data registered). After reset the block sweeps the
// whole memory to zero, one entry a cycle, and accepts no beat during the sweep;
// configuration writes are taken throughout. Items are handled one at a time and the input
// is ready only when the block is idle. A read passes through a read state, where the
// registered memory data is taken as the pending result, and then a done state, where the
// result register is loaded. A map first walks down to the first missing table to count
// the tables it needs (one memory read a level), then walks again from the root, linking
// in a new table wherever one is missing (a write, then, below the last table level, a read
// of the fresh table in a separate state), and finally writes the leaf. A map that would
// need more tables than the pool has left changes nothing and reports exhaustion. The
// result register holds a finished result while the next item is taken in; a result that
// cannot be loaded because the previous one is still waiting holds the block.
module page_table_mapping_builder_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  ptmb_in_if.sink                            in_if,
  ptmb_out_if.source                         out_if,
  input  logic                               cfg_we,
  input  logic [ptmb_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [ptmb_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ptmb_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_ADV   = 3'd4;
  localparam logic [2:0] ST_LEAF  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  function automatic logic [SLOT_W-1:0] slot_at(input logic [IDX_W-1:0] va,
                                                input logic [LVL_W-1:0] lvl);
    logic [SLOT_W-1:0] s;
    unique case (lvl)
      2'd0:    s = va[4*SLOT_W-1:3*SLOT_W];
      2'd1:    s = va[3*SLOT_W-1:2*SLOT_W];
      2'd2:    s = va[2*SLOT_W-1:SLOT_W];
      default: s = va[SLOT_W-1:0];
    endcase
    return s;
  endfunction

  logic [2:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic [CNT_W-1:0]    nfi_r, nfi_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [PPN_W-1:0]    base_r, base_nxt;
  logic                pass_r, pass_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [IDX_W-1:0]    va_r, va_nxt;
  logic [PPN_W-1:0]    pa_r, pa_nxt;
  logic                pend_status_r, pend_status_nxt;
  logic [ENTRY_W-1:0]  pend_value_r, pend_value_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_status_r;
  logic [ENTRY_W-1:0]  out_value_r;
  logic [CNT_W-1:0]    out_free_r;

  ram_req_t            req;
  logic [ENTRY_W-1:0]  rd_data;

  logic                in_fire;
  logic                out_load;
  logic                present;
  logic [PAGE_W-1:0]   next_page;
  logic [PAGE_W-1:0]   new_page;
  logic [PPN_W-1:0]    new_ppn;
  logic [NEED_W-1:0]   need;
  logic [CNT_W-1:0]    lim;

  ptmb_table_ram u_ram (
    .clk       (clk),
    .req       (req),
    .rd_data_r (rd_data)
  );

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_if.ready);

  assign present   = rd_data[0];
  assign next_page = rd_data[PAGE_SHIFT+PAGE_W-1:PAGE_SHIFT] - base_r[PAGE_W-1:0];
  assign new_page  = nfi_r[PAGE_W-1:0];
  assign new_ppn   = base_r + PPN_W'(new_page);
  assign need      = TABLE_LEVELS - NEED_W'(lvl_r);

  always_comb begin
    if (cfg_data[CNT_W-1:0] == '0) begin
      lim = CNT_W'(1);
    end else if (cfg_data[CNT_W-1:0] > POOL_LIMIT) begin
      lim = POOL_LIMIT;
    end else begin
      lim = cfg_data[CNT_W-1:0];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    nfi_nxt         = nfi_r;
    rem_nxt         = rem_r;
    base_nxt        = base_r;
    pass_nxt        = pass_r;
    lvl_nxt         = lvl_r;
    page_nxt        = page_r;
    va_nxt          = va_r;
    pa_nxt          = pa_r;
    pend_status_nxt = pend_status_r;
    pend_value_nxt  = pend_value_r;
    req             = '0;

    unique case (state_r)
      ST_CLEAR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = clr_r;
        req.wr_data = '0;
        clr_nxt     = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_if.kind == KIND_READ) begin
            req.rd_en   = 1'b1;
            req.rd_addr = {in_if.read_page, in_if.read_slot};
            state_nxt   = ST_READ;
          end else begin
            va_nxt      = in_if.virt_addr[VA_W-1:PAGE_SHIFT];
            pa_nxt      = in_if.frame_addr[PA_W-1:PAGE_SHIFT];
            pass_nxt    = 1'b0;
            lvl_nxt     = '0;
            page_nxt    = '0;
            req.rd_en   = 1'b1;
            req.rd_addr = {PAGE_W'(0), slot_at(in_if.virt_addr[VA_W-1:PAGE_SHIFT], 2'd0)};
            state_nxt   = ST_WALK;
          end
        end
      end
      ST_READ: begin
        pend_status_nxt = STATUS_DONE;
        pend_value_nxt  = rd_data;
        state_nxt       = ST_DONE;
      end
      ST_WALK: begin
        if (!pass_r) begin
          // counting walk, no writes
          if (present && lvl_r != LAST_TABLE_LVL) begin
            lvl_nxt     = lvl_r + LVL_W'(1);
            page_nxt    = next_page;
            req.rd_en   = 1'b1;
            req.rd_addr = {next_page, slot_at(va_r, lvl_r + LVL_W'(1))};
          end else if (!present && {5'b0, need} > rem_r) begin
            pend_status_nxt = STATUS_EXHAUSTED;
            pend_value_nxt  = '0;
            state_nxt       = ST_DONE;
          end else begin
            pass_nxt    = 1'b1;
            lvl_nxt     = '0;
            page_nxt    = '0;
            req.rd_en   = 1'b1;
            req.rd_addr = {PAGE_W'(0), slot_at(va_r, 2'd0)};
          end
        end else begin
          if (present) begin
            page_nxt = next_page;
            if (lvl_r != LAST_TABLE_LVL) begin
              lvl_nxt     = lvl_r + LVL_W'(1);
              req.rd_en   = 1'b1;
              req.rd_addr = {next_page, slot_at(va_r, lvl_r + LVL_W'(1))};
            end else begin
              lvl_nxt   = LEAF_LVL;
              state_nxt = ST_LEAF;
            end
          end else begin
            // allocate a table page and link it in
            req.wr_en   = 1'b1;
            req.wr_addr = {page_r, slot_at(va_r, lvl_r)};
            req.wr_data = {12'b0, new_ppn, FLAGS_PW};
            nfi_nxt     = nfi_r + CNT_W'(1);
            rem_nxt     = rem_r - CNT_W'(1);
            page_nxt    = new_page;
            if (lvl_r != LAST_TABLE_LVL) begin
              lvl_nxt   = lvl_r + LVL_W'(1);
              state_nxt = ST_ADV;
            end else begin
              lvl_nxt   = LEAF_LVL;
              state_nxt = ST_LEAF;
            end
          end
        end
      end
      ST_ADV: begin
        req.rd_en   = 1'b1;
        req.rd_addr = {page_r, slot_at(va_r, lvl_r)};
        state_nxt   = ST_WALK;
      end
      ST_LEAF: begin
        req.wr_en       = 1'b1;
        req.wr_addr     = {page_r, slot_at(va_r, LEAF_LVL)};
        req.wr_data     = {12'b0, pa_r, FLAGS_PW};
        pend_status_nxt = STATUS_DONE;
        pend_value_nxt  = {12'b0, pa_r, FLAGS_PW};
        state_nxt       = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_POOL_BASE: begin
          base_nxt = cfg_data[PPN_W-1:0];
        end
        CFG_POOL_COUNT: begin
          rem_nxt = (lim > nfi_r) ? lim - nfi_r : '0;
        end
        default: begin
          base_nxt = base_r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      nfi_r       <= NFI_RESET;
      rem_r       <= REM_RESET;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      nfi_r       <= nfi_nxt;
      rem_r       <= rem_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pass_r        <= pass_nxt;
    lvl_r         <= lvl_nxt;
    page_r        <= page_nxt;
    va_r          <= va_nxt;
    pa_r          <= pa_nxt;
    pend_status_r <= pend_status_nxt;
    pend_value_r  <= pend_value_nxt;
    if (out_load) begin
      out_status_r <= pend_status_r;
      out_value_r  <= pend_value_r;
      out_free_r   <= rem_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.entry_value = out_value_r;
  assign out_if.free_pages  = out_free_r;

endmodule

FILE: rtl/ptmb_checker.sv
module ptmb_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_status,
  input logic [ptmb_pkg::ENTRY_W-1:0]      out_entry_value,
  input logic [ptmb_pkg::CNT_W-1:0]        out_free_pages
);
  import ptmb_pkg::*;

  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back to back cycles");

  // exhausted map leaves nothing behind
  a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_EXHAUSTED |-> out_entry_value == '0)
    else $error("exhausted result carries an entry");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_value)
      && $stable(out_status) && $stable(out_free_pages))
    else $error("stalled result beat changed");

  // no result and no intake right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("block active after reset");

endmodule

bind page_table_mapping_builder_unit ptmb_checker u_ptmb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_status      (out_if.status),
  .out_entry_value (out_if.entry_value),
  .out_free_pages  (out_if.free_pages)
);
